// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL.
// Each expects a clock named clk in scope; ASSERT_CLK also expects a reset named rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside of reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and codes of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  typedef logic [1:0] kind_t;

  // result classification
  localparam kind_t KIND_TWO    = 2'd0;  // two distinct real roots
  localparam kind_t KIND_DOUBLE = 2'd1;  // one double root
  localparam kind_t KIND_NONE   = 2'd2;  // no real roots
  localparam kind_t KIND_AZERO  = 2'd3;  // leading coefficient zero

  // root format: signed Q16.16
  localparam int ROOT_W    = 32;
  localparam int ROOT_FRAC = 16;

endpackage

// ===== src/qrs_sqrt.sv =====
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt #(
  parameter int RW  = 33,
  parameter int SBW = 34
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [2*RW-1:0]   in_rad,
  input  logic [SBW-1:0]    in_sb,
  output logic              out_vld,
  output logic [RW-1:0]     out_root,
  output logic [SBW-1:0]    out_sb
);

  logic              vld  [RW+1];
  logic [2*RW-1:0]   rad  [RW+1];
  logic [RW+1:0]     rem  [RW+1];
  logic [RW-1:0]     root [RW+1];
  logic [SBW-1:0]    sb   [RW+1];

  // stage 0 is the input request
  assign vld[0]  = in_vld;
  assign rad[0]  = in_rad;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign sb[0]   = in_sb;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+3:0] cur;
    logic [RW+3:0] trial;
    logic [RW+3:0] diff;
    logic          ge;

    // bring down two radicand bits, try root*4+1
    assign cur   = {rem[k], rad[k][2*RW-1:2*RW-2]};
    assign trial = (RW+4)'({root[k], 2'b01});
    assign diff  = cur - trial;
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[k+1]  <= rad[k] << 2;
        rem[k+1]  <= ge ? diff[RW+1:0] : cur[RW+1:0];
        root[k+1] <= {root[k][RW-2:0], ge};
        sb[k+1]   <= sb[k];
      end
    end
  end

  assign out_vld  = vld[RW];
  assign out_root = root[RW];
  assign out_sb   = sb[RW];

endmodule

// ===== src/qrs_div.sv =====
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrs_div #(
  parameter int NW  = 36,
  parameter int DW  = 18,
  parameter int SBW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  logic [NW-1:0]   in_num,
  input  logic [DW-1:0]   in_den,
  input  logic [SBW-1:0]  in_sb,
  output logic            out_vld,
  output logic [NW-1:0]   out_quo,
  output logic [SBW-1:0]  out_sb
);

  logic            vld [NW+1];
  logic [NW-1:0]   num [NW+1];
  logic [NW-1:0]   quo [NW+1];
  logic [DW-1:0]   rem [NW+1];
  logic [DW-1:0]   den [NW+1];
  logic [SBW-1:0]  sb  [NW+1];

  // stage 0 is the input request
  assign vld[0] = in_vld;
  assign num[0] = in_num;
  assign quo[0] = '0;
  assign rem[0] = '0;
  assign den[0] = in_den;
  assign sb[0]  = in_sb;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW:0] cur;
    logic [DW:0] diff;
    logic        ge;

    // shift in next numerator bit, subtract divisor if it fits
    assign cur  = {rem[k], num[k][NW-1]};
    assign diff = cur - {1'b0, den[k]};
    assign ge   = (cur >= {1'b0, den[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num[k+1] <= num[k] << 1;
        quo[k+1] <= {quo[k][NW-2:0], ge};
        rem[k+1] <= ge ? diff[DW-1:0] : cur[DW-1:0];
        den[k+1] <= den[k];
        sb[k+1]  <= sb[k];
      end
    end
  end

  assign out_vld = vld[NW];
  assign out_quo = quo[NW];
  assign out_sb  = sb[NW];

endmodule

// ===== src/quadratic_root_solver.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c = 0 from fixed-point coefficients.
// ----------------------------------------------------------------------------
// Takes one coefficient set per cycle while the output is not stalled and
// returns one result per set, in order. The path runs through the square
// root pipeline (COEF_WIDTH + 17 stages, one root bit each) followed by two
// parallel dividers (COEF_WIDTH + 20 stages, one quotient bit each). The
// whole pipeline advances whenever the output register is empty or being
// read, so a stalled output holds every request in place. Roots are signed
// Q16.16, rounded to nearest (ties away from zero) and saturated; the kind
// code tells two roots, a double root, no real roots, or a zero leading
// coefficient (roots then read zero).
`include "assert_macros.svh"

module quadratic_root_solver #(
  parameter int COEF_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // s_tdata: coef_a, coef_b, coef_c (lowest bits first), zero padded
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]     s_tdata,
  // m_tdata: root_plus [31:0], root_minus [63:32]
  // m_tuser: root_kind
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [2*qrs_pkg::ROOT_W-1:0]          m_tdata,
  output logic [1:0]                            m_tuser
);

  localparam int W    = COEF_WIDTH;
  localparam int PW   = 2*W;       // product width
  localparam int DW   = 2*W + 1;   // discriminant width
  localparam int RW   = W + 17;    // scaled square root width
  localparam int NUMW = W + 19;    // signed root numerator
  localparam int UW   = W + 18;    // numerator magnitude
  localparam int QW   = W + 20;    // divider dividend and quotient
  localparam int DENW = W + 2;     // divider divisor
  localparam int RTW  = qrs_pkg::ROOT_W;

  logic en;

  // pipeline advances unless the output holds an untaken result
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // stage 1: register coefficients
  logic                v1;
  logic signed [W-1:0] a1, b1, c1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= s_tdata[W-1:0];
      b1 <= s_tdata[2*W-1:W];
      c1 <= s_tdata[3*W-1:2*W];
    end
  end

  // magnitudes
  logic [W-1:0] ma1, mb1, mc1;
  assign ma1 = a1[W-1] ? W'(-a1) : W'(a1);
  assign mb1 = b1[W-1] ? W'(-b1) : W'(b1);
  assign mc1 = c1[W-1] ? W'(-c1) : W'(c1);

  // stage 2: b*b and a*c
  logic                v2;
  logic [PW-1:0]       bsq2, ac2;
  logic signed [W-1:0] a2, b2;
  logic                cn2, az2, cz2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bsq2 <= mb1 * mb1;
      ac2  <= ma1 * mc1;
      a2   <= a1;
      b2   <= b1;
      cn2  <= c1[W-1];
      az2  <= (a1 == '0);
      cz2  <= (c1 == '0);
    end
  end

  // discriminant and classification
  logic [DW-1:0]     fac, bsqx, disc;
  qrs_pkg::kind_t    kind;

  assign fac  = DW'({ac2, 2'b00});
  assign bsqx = DW'(bsq2);

  always_comb begin
    disc = '0;
    kind = qrs_pkg::KIND_TWO;
    if (az2) begin
      kind = qrs_pkg::KIND_AZERO;
    end else if ((a2[W-1] != cn2) || cz2) begin
      disc = bsqx + fac;
    end else if (bsqx >= fac) begin
      disc = bsqx - fac;
    end else begin
      kind = qrs_pkg::KIND_NONE;
    end
    if (kind == qrs_pkg::KIND_TWO && disc == '0) begin
      kind = qrs_pkg::KIND_DOUBLE;
    end
  end

  // stage 3
  logic                v3;
  logic [DW-1:0]       d3;
  qrs_pkg::kind_t      k3;
  logic signed [W-1:0] a3, b3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d3 <= disc;
      k3 <= kind;
      a3 <= a2;
      b3 <= b2;
    end
  end

  // square root of disc * 2^32
  logic           sq_vld;
  logic [RW-1:0]  sq;
  logic [PW+1:0]  sq_sb;

  qrs_sqrt #(
    .RW  (RW),
    .SBW (PW + 2)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (v3),
    .in_rad   ({1'b0, d3, 32'd0}),
    .in_sb    ({k3, a3, b3}),
    .out_vld  (sq_vld),
    .out_root (sq),
    .out_sb   (sq_sb)
  );

  // numerators -b*2^16 +/- s and divider operands
  logic signed [W-1:0]    as4, bs4;
  qrs_pkg::kind_t         ks4;
  logic signed [NUMW-1:0] nb, sqs, nump, numm;
  logic [UW-1:0]          unp, unm;
  logic signed [W:0]      ase;
  logic [W:0]             ud;

  assign ks4  = sq_sb[PW+1:PW];
  assign as4  = sq_sb[PW-1:W];
  assign bs4  = sq_sb[W-1:0];
  assign nb   = -(NUMW'(bs4) <<< qrs_pkg::ROOT_FRAC);
  assign sqs  = $signed({2'b00, sq});
  assign nump = nb + sqs;
  assign numm = nb - sqs;
  assign unp  = nump[NUMW-1] ? UW'(-nump) : UW'(nump);
  assign unm  = numm[NUMW-1] ? UW'(-numm) : UW'(numm);
  assign ase  = (W+1)'(as4);
  assign ud   = ase[W] ? $unsigned(-ase) : $unsigned(ase);

  // stage 4: rounding dividend 2|num| + |den|, divisor 2|den| with |den| = 2|a|
  logic             v4;
  logic [QW-1:0]    np4, nm4;
  logic [DENW-1:0]  den4;
  logic             negp4, negm4;
  qrs_pkg::kind_t   k4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      np4   <= QW'({unp, 1'b0}) + QW'({ud, 1'b0});
      nm4   <= QW'({unm, 1'b0}) + QW'({ud, 1'b0});
      den4  <= DENW'({ud, 2'b00});
      negp4 <= nump[NUMW-1] != as4[W-1];
      negm4 <= numm[NUMW-1] != as4[W-1];
      k4    <= ks4;
    end
  end

  // two dividers in lockstep
  logic           dv_vld;
  logic [QW-1:0]  qp, qm;
  logic [2:0]     dp_sb;
  logic           negm5;

  qrs_div #(
    .NW  (QW),
    .DW  (DENW),
    .SBW (3)
  ) u_div_plus (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (v4),
    .in_num  (np4),
    .in_den  (den4),
    .in_sb   ({k4, negp4}),
    .out_vld (dv_vld),
    .out_quo (qp),
    .out_sb  (dp_sb)
  );

  qrs_div #(
    .NW  (QW),
    .DW  (DENW),
    .SBW (1)
  ) u_div_minus (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (v4),
    .in_num  (nm4),
    .in_den  (den4),
    .in_sb   (negm4),
    .out_vld (),
    .out_quo (qm),
    .out_sb  (negm5)
  );

  // sign and saturation
  qrs_pkg::kind_t  k5;
  logic [63:0]     qpx, qmx;
  logic [RTW-1:0]  rp, rm;

  assign k5  = dp_sb[2:1];
  assign qpx = 64'(qp);
  assign qmx = 64'(qm);

  always_comb begin
    if (dp_sb[0]) begin
      rp = (qpx > 64'h8000_0000) ? 32'h8000_0000 : RTW'(-qpx);
    end else begin
      rp = (qpx > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : qpx[RTW-1:0];
    end
    if (negm5) begin
      rm = (qmx > 64'h8000_0000) ? 32'h8000_0000 : RTW'(-qmx);
    end else begin
      rm = (qmx > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : qmx[RTW-1:0];
    end
    if (k5 == qrs_pkg::KIND_NONE || k5 == qrs_pkg::KIND_AZERO) begin
      rp = '0;
      rm = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {rm, rp};
      m_tuser <= k5;
    end
  end

  // checks
  `ASSERT_CLK(a_noroot_zero,
    m_tvalid && (m_tuser == qrs_pkg::KIND_NONE || m_tuser == qrs_pkg::KIND_AZERO)
      |-> m_tdata == '0, "no-root result carries nonzero roots")
  `ASSERT_CLK(a_double_equal,
    m_tvalid && m_tuser == qrs_pkg::KIND_DOUBLE |-> m_tdata[RTW-1:0] == m_tdata[2*RTW-1:RTW],
    "double root with unequal roots")
  `ASSERT_CLK(a_two_disc_nonzero,
    v3 && k3 == qrs_pkg::KIND_TWO |-> d3 != '0, "two roots with zero discriminant")

endmodule

// ===== sim/tb_quadratic_root_solver.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quadratic_root_solver
// Self-checking bench for the quadratic root solver.
// ----------------------------------------------------------------------------
// Coefficient sets are queued by an initial block, driven by a clocked
// driver with random gaps, and the roots expected for each accepted request
// are computed here in wide integer arithmetic. A clocked monitor with random
// backpressure compares each result, field by field, with the oldest
// expectation.
module tb_quadratic_root_solver;

  localparam int CW = 16;
  localparam int DW = ((3 * CW + 7) / 8) * 8;
  localparam int RW = qrs_pkg::ROOT_W;

  typedef struct packed {
    logic signed [CW-1:0] coef_c;
    logic signed [CW-1:0] coef_b;
    logic signed [CW-1:0] coef_a;
  } coef_set_t;

  typedef struct {
    qrs_pkg::kind_t       kind;
    logic signed [RW-1:0] rplus;
    logic signed [RW-1:0] rminus;
  } roots_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [DW-1:0] s_tdata = '0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [2*RW-1:0] m_tdata;
  logic [1:0]    m_tuser;

  coef_set_t pending_sets[$];
  roots_t    expected_roots[$];
  bit        stim_done = 1'b0;
  bit        failed = 1'b0;
  bit        calm = 1'b0;   // stretch with no idling on either side

  quadratic_root_solver #(.COEF_WIDTH(CW)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #2 clk = ~clk;

  // Floor square root of a nonnegative 96-bit value
  function automatic logic [95:0] isqrt96(input logic [95:0] x);
    logic [95:0] rem, res, bitv;
    rem = x; res = '0; bitv = 96'd1 << 94;
    while (bitv != 0 && bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Rounded (ties away from zero), saturated Q16.16 quotient
  function automatic logic signed [RW-1:0] div_round(input longint num, input longint den);
    longint unsigned un, ud, q;
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    q = (2 * un + ud) / (2 * ud);
    if ((num < 0) != (den < 0))
      return q > 64'h8000_0000 ? 32'sh8000_0000 : -$signed(q[31:0]);
    return q > 64'h7FFF_FFFF ? 32'sh7FFF_FFFF : q[31:0];
  endfunction

  function automatic roots_t solve_roots(input coef_set_t cs);
    roots_t r;
    longint a, b, c, disc, sq, nb;
    a = cs.coef_a; b = cs.coef_b; c = cs.coef_c;
    r.rplus = '0; r.rminus = '0;
    if (a == 0) begin
      r.kind = qrs_pkg::KIND_AZERO;
      return r;
    end
    disc = b * b - 4 * a * c;
    if (disc < 0) begin
      r.kind = qrs_pkg::KIND_NONE;
      return r;
    end
    r.kind = disc == 0 ? qrs_pkg::KIND_DOUBLE : qrs_pkg::KIND_TWO;
    sq = longint'(isqrt96(96'(disc) << 32));
    nb = -b * 65536;
    r.rplus = div_round(nb + sq, 2 * a);
    r.rminus = div_round(nb - sq, 2 * a);
    return r;
  endfunction

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 36);
  endfunction

  // Driver: one request per handshake, random gaps
  always @(posedge clk) begin
    if (!rst) begin
      if (!s_tvalid || s_tready) begin
        if (pending_sets.size() > 0 && !idle_now()) begin
          coef_set_t cs;
          cs = pending_sets.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= DW'(cs);
          expected_roots.push_back(solve_roots(cs));
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check accepted results, random backpressure
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_roots.size() == 0) begin
          $error("unexpected result: kind %0d data %h", m_tuser, m_tdata);
          failed = 1'b1;
        end else begin
          roots_t e;
          e = expected_roots.pop_front();
          if (m_tuser !== e.kind) begin
            $error("root_kind: expected %0d, actual %0d", e.kind, m_tuser);
            failed = 1'b1;
          end
          if (m_tdata[31:0] !== e.rplus) begin
            $error("root_plus: expected %0d, actual %0d", e.rplus, $signed(m_tdata[31:0]));
            failed = 1'b1;
          end
          if (m_tdata[63:32] !== e.rminus) begin
            $error("root_minus: expected %0d, actual %0d", e.rminus,
                   $signed(m_tdata[63:32]));
            failed = 1'b1;
          end
        end
      end
      m_tready <= !idle_now();
    end
  end

  function automatic logic [CW-1:0] rand_coef();
    case ($urandom_range(5))
      0: return CW'($urandom_range(8) - 4);
      1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return CW'($urandom);
    endcase
  endfunction

  // Stimulus
  initial begin
    coef_set_t cs;
    int k;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes, each kind, rounding and saturation corners
    pending_sets.push_back('{coef_c: 16'sd0, coef_b: 16'sd0, coef_a: 16'sd0});
    pending_sets.push_back('{coef_c: 16'sh7FFF, coef_b: 16'sh8000, coef_a: 16'sd0});
    pending_sets.push_back('{coef_c: -16'sd256, coef_b: 16'sd0, coef_a: 16'sd256});
    pending_sets.push_back('{coef_c: 16'sd256, coef_b: -16'sd512, coef_a: 16'sd256});
    pending_sets.push_back('{coef_c: 16'sd256, coef_b: 16'sd0, coef_a: 16'sd256});
    pending_sets.push_back('{coef_c: 16'sd256, coef_b: 16'sd0, coef_a: -16'sd256});
    pending_sets.push_back('{coef_c: 16'sh8000, coef_b: 16'sh8000, coef_a: 16'sd1});
    pending_sets.push_back('{coef_c: 16'sh7FFF, coef_b: 16'sh7FFF, coef_a: -16'sd1});
    pending_sets.push_back('{coef_c: 16'sh8000, coef_b: 16'sh8000, coef_a: 16'sh8000});
    pending_sets.push_back('{coef_c: 16'sh7FFF, coef_b: 16'sh7FFF, coef_a: 16'sh7FFF});
    pending_sets.push_back('{coef_c: 16'sh8000, coef_b: 16'sh7FFF, coef_a: 16'sh7FFF});
    pending_sets.push_back('{coef_c: 16'sd0, coef_b: 16'sd1, coef_a: 16'sd4});
    pending_sets.push_back('{coef_c: 16'sd1, coef_b: 16'sd2, coef_a: 16'sd1});
    pending_sets.push_back('{coef_c: 16'sd0, coef_b: 16'sd0, coef_a: -16'sd3});
    pending_sets.push_back('{coef_c: 16'sd0, coef_b: -16'sd1, coef_a: 16'sd1});
    pending_sets.push_back('{coef_c: 16'sh7FFF, coef_b: 16'sd0, coef_a: 16'sh8000});
    // random: mostly real-root sets, with double roots from b = 2k, a = 1
    for (int i = 0; i < 1500; i++) begin
      cs.coef_a = rand_coef();
      cs.coef_b = rand_coef();
      cs.coef_c = rand_coef();
      if ($urandom_range(9) == 0) begin
        k = $urandom_range(180) - 90;
        cs.coef_a = 16'sd1; cs.coef_b = CW'(2 * k); cs.coef_c = CW'(k * k);
      end else if ($urandom_range(2) == 0 && cs.coef_a != 0) begin
        cs.coef_c = -cs.coef_c;
        if ((cs.coef_a < 0) == (cs.coef_c < 0)) cs.coef_c = -cs.coef_c;
      end
      pending_sets.push_back(cs);
      if (i == 700) pending_sets.push_back(cs);
    end
    // no idling while the middle part streams
    wait (pending_sets.size() < 900);
    calm = 1'b1;
    wait (pending_sets.size() < 600);
    calm = 1'b0;
    wait (pending_sets.size() == 0 && (!s_tvalid || s_tready));
    @(posedge clk);
    wait (expected_roots.size() == 0);
    repeat (100) @(posedge clk);
    if (!failed && expected_roots.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/qrs_pkg.sv
src/qrs_sqrt.sv
src/qrs_div.sv
src/quadratic_root_solver.sv
sim/tb_quadratic_root_solver.sv
